@@ rtl/sttpg_pkg.sv @@
// Shared types, widths and constants of the trapezoidal stepper pulse generator.
// No dependencies; every other file refers to it by scoped names.
package sttpg_pkg;

  // Internal counter and delay widths
  localparam int COUNT_BITS = 20;
  localparam int DELAY_BITS = 16;

  // Fixed field and register widths
  localparam int STEP_FIELD_BITS = 20;
  localparam int HP_CFG_BITS     = 16;
  localparam int INC_BITS        = 10;
  localparam int RAMP_BITS       = 20;
  localparam int CFG_DATA_BITS   = 20;
  localparam int CFG_IDX_BITS    = 2;

  // Stream widths (payload padded to whole bytes)
  localparam int S_TDATA_BITS = 24;
  localparam int M_TDATA_BITS = 8;
  localparam int RES_BITS     = 4;

  // Working widths for threshold and delay arithmetic
  localparam int THR_BITS = ((COUNT_BITS > RAMP_BITS) ? COUNT_BITS : RAMP_BITS) + 1;
  localparam int SUM_MAX0 = (DELAY_BITS > HP_CFG_BITS) ? DELAY_BITS : HP_CFG_BITS;
  localparam int SUM_BITS = ((SUM_MAX0 > INC_BITS) ? SUM_MAX0 : INC_BITS) + 1;

  // Register reset values
  localparam logic [HP_CFG_BITS-1:0] HP_RST   = HP_CFG_BITS'(4000);
  localparam logic [INC_BITS-1:0]    INC_RST  = INC_BITS'(7);
  localparam logic [RAMP_BITS-1:0]   RAMP_RST = RAMP_BITS'(530);

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_START_HP  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_INC = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_RAMP      = CFG_IDX_BITS'(2);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [HP_CFG_BITS-1:0] start_half_period;
    logic [INC_BITS-1:0]    delay_increment;
    logic [RAMP_BITS-1:0]   ramp_steps;
  } cfg_t;

  typedef struct packed {
    cmd_e                       command;
    logic                       direction;
    logic [STEP_FIELD_BITS-1:0] step_count;
  } item_t;

  // Declared MSB first: pulse_level lands in bit 0
  typedef struct packed {
    logic move_done;
    logic busy_res;
    logic direction_level;
    logic pulse_level;
  } res_t;

  // Saturate a delay value at the top of the delay range
  function automatic logic [DELAY_BITS-1:0] sat_delay(input logic [SUM_BITS-1:0] v);
    logic [DELAY_BITS-1:0] r;
    if (v[SUM_BITS-1:DELAY_BITS] != '0) begin
      r = '1;
    end else begin
      r = v[DELAY_BITS-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/sttpg_cfg_regs.sv @@
// Configuration register file: start half-period, delay increment, ramp length.
// Depends on sttpg_pkg.
module sttpg_cfg_regs (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [sttpg_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [sttpg_pkg::CFG_DATA_BITS-1:0]    cfg_wdata_i,
  output sttpg_pkg::cfg_t                        cfg_o
);

  sttpg_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        sttpg_pkg::REG_START_HP: begin
          cfg_d.start_half_period = cfg_wdata_i[sttpg_pkg::HP_CFG_BITS-1:0];
        end
        sttpg_pkg::REG_DELAY_INC: begin
          cfg_d.delay_increment = cfg_wdata_i[sttpg_pkg::INC_BITS-1:0];
        end
        sttpg_pkg::REG_RAMP: begin
          cfg_d.ramp_steps = cfg_wdata_i[sttpg_pkg::RAMP_BITS-1:0];
        end
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_half_period <= sttpg_pkg::HP_RST;
      cfg_q.delay_increment   <= sttpg_pkg::INC_RST;
      cfg_q.ramp_steps        <= sttpg_pkg::RAMP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/sttpg_core.sv @@
// Move state and per-tick step logic: ramp thresholds, delay update, phase counter.
// Depends on sttpg_pkg.
module sttpg_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  sttpg_pkg::item_t   item_i,
  input  sttpg_pkg::cfg_t    cfg_i,
  output sttpg_pkg::res_t    res_o
);

  localparam int CB = sttpg_pkg::COUNT_BITS;
  localparam int DB = sttpg_pkg::DELAY_BITS;
  localparam int TB = sttpg_pkg::THR_BITS;
  localparam int SB = sttpg_pkg::SUM_BITS;

  logic          moving_q, moving_d;
  logic          dir_q, dir_d;
  logic [CB-1:0] total_q, total_d;
  logic [CB-1:0] idx_q, idx_d;
  logic [DB-1:0] hp_q, hp_d;
  logic [DB-1:0] tick_q, tick_d;
  logic          high_q, high_d;

  // Start count and ramp thresholds: fall while index < lo, rise while index > hi.
  // The thresholds follow the live ramp register so a new ramp length applies
  // at the next step.
  logic [CB-1:0] n;
  logic [TB-1:0] n_w, r_w, two_r1, n_plus, hi_short, lo_thr, hi_thr;
  logic          long_move;

  // Tick-time terms
  logic [TB-1:0] idx_w;
  logic          step_start, fall, rise;
  logic [SB-1:0] hp_w, inc_w, hp_raw;
  logic [DB-1:0] hp_new, hp_eff, tick_eff, tick_dec;
  logic          high_eff;
  logic [CB-1:0] idx_inc;
  logic          pulse, done;

  always_comb begin
    n         = CB'(item_i.step_count);
    n_w       = TB'(total_q);
    r_w       = TB'(cfg_i.ramp_steps);
    two_r1    = TB'({cfg_i.ramp_steps, 1'b1});
    long_move = n_w > two_r1;
    n_plus    = n_w + TB'(total_q[0]);
    hi_short  = n_plus >> 1;
    lo_thr    = long_move ? r_w : (n_w >> 1);
    hi_thr    = long_move ? (n_w - r_w) : hi_short;
  end

  always_comb begin
    idx_w      = TB'(idx_q);
    step_start = !high_q && (tick_q == '0);
    fall       = idx_w < lo_thr;
    rise       = idx_w > hi_thr;
    hp_w       = SB'(hp_q);
    inc_w      = SB'(cfg_i.delay_increment);
    if (fall) begin
      hp_raw = (hp_w > inc_w) ? (hp_w - inc_w) : '0;
    end else if (rise) begin
      hp_raw = hp_w + inc_w;
    end else begin
      hp_raw = hp_w;
    end
    // Floor at one, ceiling at the top of the delay range
    hp_new   = (hp_raw == '0) ? DB'(1) : sttpg_pkg::sat_delay(hp_raw);
    hp_eff   = step_start ? hp_new : hp_q;
    tick_eff = step_start ? hp_new : tick_q;
    high_eff = step_start || high_q;
    tick_dec = tick_eff - DB'(1);
    idx_inc  = idx_q + CB'(1);
  end

  always_comb begin
    moving_d = moving_q;
    dir_d    = dir_q;
    total_d  = total_q;
    idx_d    = idx_q;
    hp_d     = hp_q;
    tick_d   = tick_q;
    high_d   = high_q;
    pulse    = 1'b0;
    done     = 1'b0;
    case (item_i.command)
      sttpg_pkg::CMD_START: begin
        if (!moving_q) begin
          dir_d    = item_i.direction;
          total_d  = n;
          idx_d    = '0;
          hp_d     = sttpg_pkg::sat_delay(SB'(cfg_i.start_half_period));
          tick_d   = '0;
          high_d   = 1'b0;
          moving_d = (n != '0);
          done     = (n == '0);
        end
      end
      sttpg_pkg::CMD_TICK: begin
        if (moving_q) begin
          pulse = high_eff;
          hp_d  = hp_eff;
          if (tick_dec == '0) begin
            if (high_eff) begin
              // high half done: hold low for the same count
              high_d = 1'b0;
              tick_d = hp_eff;
            end else begin
              // low half done: advance to the next step
              high_d = 1'b0;
              tick_d = '0;
              idx_d  = idx_inc;
              if (idx_inc >= total_q) begin
                moving_d = 1'b0;
                done     = 1'b1;
              end
            end
          end else begin
            high_d = high_eff;
            tick_d = tick_dec;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      moving_q <= 1'b0;
      dir_q    <= 1'b0;
      total_q  <= '0;
      idx_q    <= '0;
      hp_q     <= sttpg_pkg::sat_delay(SB'(sttpg_pkg::HP_RST));
      tick_q   <= '0;
      high_q   <= 1'b0;
    end else if (fire_i) begin
      moving_q <= moving_d;
      dir_q    <= dir_d;
      total_q  <= total_d;
      idx_q    <= idx_d;
      hp_q     <= hp_d;
      tick_q   <= tick_d;
      high_q   <= high_d;
    end
  end

  assign res_o.pulse_level     = pulse;
  assign res_o.direction_level = dir_d;
  assign res_o.busy_res        = moving_d;
  assign res_o.move_done       = done;

endmodule

@@ rtl/stepper_trapezoid_pulse_gen_top.sv @@
// Top level of the trapezoidal stepper pulse generator: stream ports, input and
// result registers. Depends on sttpg_pkg, sttpg_cfg_regs and sttpg_core.
//
// Usage
//   Slave stream (s_axis_*): one transaction per command. tuser carries the
//   command (0 = start a move, 1 = one time tick). tdata carries step_count in
//   bits [19:0] and direction in bit 20; both matter on start only.
//   Master stream (m_axis_*): exactly one result transaction per command, in
//   order. tdata bit 0 pulse_level, bit 1 direction_level, bit 2 busy_res,
//   bit 3 move_done.
//   Config port: write register cfg_idx_i with cfg_wdata_i when cfg_we_i is
//   high (0 start half-period, 1 delay increment, 2 ramp steps). Write only
//   while no command is in flight. A new increment or ramp length applies from
//   the next step's delay update; a new start half-period from the next start.
// Timing
//   A command is taken into the input register and processed into the result
//   register once that register is free or draining; the result is presented there
//   until the receiver takes it. Throughput is one command per cycle while the
//   master stream is not stalled; the state update for a tick (ramp thresholds, delay
//   update, phase counter, step index) is combinational ahead of the result register.
// Reset
//   Asynchronous, active low: both stream stages empty, no move in progress,
//   registers back to 4000 / 7 / 530.
// Stalls
//   When m_axis_tready_i is low the result holds; the input register still
//   takes one more command, then s_axis_tready_o drops until the result moves.
module stepper_trapezoid_pulse_gen_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Slave stream
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [19:0] step_count, [20] direction, [23:21] zero
  input  logic [sttpg_pkg::S_TDATA_BITS-1:0]   s_axis_tdata_i,
  // [0] command
  input  logic                                 s_axis_tuser_i,
  // Master stream
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [0] pulse_level, [1] direction_level, [2] busy_res, [3] move_done, [7:4] zero
  output logic [sttpg_pkg::M_TDATA_BITS-1:0]   m_axis_tdata_o,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [sttpg_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [sttpg_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);

  sttpg_pkg::cfg_t  cfg;
  sttpg_pkg::item_t in_item_q;
  sttpg_pkg::res_t  res_comb;
  sttpg_pkg::res_t  res_q;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             fire;

  // Process the held command whenever the result register is free or draining
  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // Payload register: no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q.command    <= sttpg_pkg::cmd_e'(s_axis_tuser_i);
      in_item_q.direction  <= s_axis_tdata_i[sttpg_pkg::STEP_FIELD_BITS];
      in_item_q.step_count <= s_axis_tdata_i[sttpg_pkg::STEP_FIELD_BITS-1:0];
    end
  end

  sttpg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sttpg_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res_comb)
  );

  // Result register: load on fire, drop valid once the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_comb;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(sttpg_pkg::M_TDATA_BITS - sttpg_pkg::RES_BITS){1'b0}}, res_q};

endmodule

@@ rtl/sttpg_checker.sv @@
// Port-level checker for the trapezoidal stepper pulse generator, bound to the top.
// Depends on sttpg_pkg and stepper_trapezoid_pulse_gen_top.
module sttpg_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tready_o,
  input logic                                 m_axis_tvalid_o,
  input logic                                 m_axis_tready_i,
  input logic [sttpg_pkg::M_TDATA_BITS-1:0]   m_axis_tdata_o
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Input side only backs up behind a stalled, full result register
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  // A completing move is no longer busy
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[3] |-> !m_axis_tdata_o[2])
    else $error("move_done with busy set");

  // Pulses only come out of a running move
  a_pulse_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[2] && !m_axis_tdata_o[3])
    else $error("pulse outside of a move");

endmodule

bind stepper_trapezoid_pulse_gen_top sttpg_checker u_sttpg_checker (.*);
